// ----- design/nwu_pkg.sv -----
`timescale 1ns / 1ps
package nwu_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);

  // widths of the serial datapath
  localparam int MW     = 82;
  localparam int DNW    = 88;
  localparam int DRW    = 49;
  localparam int DQW    = 57;
  localparam int SXW    = 96;
  localparam int SRW    = 50;
  localparam int RTW    = 48;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] MUL_STEPS  = CNT_W'(32);
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(DNW);
  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(RTW);

  localparam logic [32:0]    POW_ONE   = 33'h1_0000_0000;
  localparam logic [24:0]    Q24_ONE   = 25'h100_0000;
  localparam logic [DQW-1:0] CAP39     = DQW'((64'd1 << 39) - 64'd1);
  localparam logic [DQW-1:0] CAP56     = DQW'((64'd1 << 56) - 64'd1);
  localparam logic [DQW-1:0] CAP_NEG   = DQW'(64'd1 << 31);
  localparam logic [DQW-1:0] CAP_POS   = DQW'((64'd1 << 31) - 64'd1);

  localparam logic [23:0] BETA_FIRST_RST  = 24'd15099494;
  localparam logic [23:0] BETA_SECOND_RST = 24'd16760439;
  localparam logic [23:0] ETA_RST         = 24'd0;
  localparam logic [39:0] EPS_RST         = 40'd10995;

  typedef enum logic [1:0] {
    CFG_BETA_FIRST,
    CFG_BETA_SECOND,
    CFG_LEARNING_RATE,
    CFG_STABILITY_TERM
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_P1,
    ST_P2,
    ST_GT,
    ST_M,
    ST_GSQ,
    ST_V1,
    ST_V2,
    ST_WRITE,
    ST_DMH,
    ST_DGH,
    ST_DVH,
    ST_SQRT,
    ST_NUM,
    ST_NMAG,
    ST_DDEL,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic [9:0]         slot_index;
    logic signed [31:0] gradient;
    logic               call_start;
  } nwu_in_t;

  typedef struct packed {
    logic signed [31:0] weight_delta;
    logic               saturated;
  } nwu_out_t;

  typedef struct packed {
    logic first;
    logic last;
    logic is_mul;
    logic is_div;
    logic is_sqrt;
  } nwu_ctl_t;

endpackage

// ----- design/nadam_weight_update_unit.sv -----
`timescale 1ns / 1ps
// nadam weight update: one gradient element in, one weight delta out.
// input channel: in_valid_i / in_ready_o with in_item_i (slot, gradient,
// call_start); output channel: out_valid_o / out_ready_i with out_item_o.
// config channel: cfg_valid_i / cfg_ready_o, always ready, index and data.
// each item runs through one shared bit-serial multiplier (1 bit/cycle),
// one restoring divider (1 quotient bit/cycle, 88 steps) and one
// square-root unit (1 root bit/cycle, 48 steps) under a sequencer.
// one item at a time: the next item is taken only once the previous one
// has run through the whole sequence, whose length is set mostly by the
// four divides and the square root and which is longer when call_start
// is set.
// after reset the valid bits of all 1024 slots are cleared one per cycle,
// so in_ready_o stays low until the clear is done; config writes are taken anyway.
// the result waits in an output register; a new item is accepted while it
// waits, and a stalled receiver holds the sequencer only at its last step.
module nadam_weight_update_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nwu_pkg::nwu_in_t   in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nwu_pkg::nwu_out_t  out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  nwu_pkg::cfg_idx_e  cfg_index_i,
  input  logic [39:0]        cfg_data_i
);
  import nwu_pkg::*;

  st_e               state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] clr_idx_q;
  nwu_ctl_t          ctl;
  logic              accept;

  logic [23:0] b1_q, b2_q, eta_q;
  logic [39:0] eps_q;
  logic [32:0] p1_q, p2_q;

  logic              out_valid_q;
  nwu_out_t          out_q;

  // item payload
  logic [SLOT_W-1:0]  slot_q;
  logic signed [31:0] g_q;
  logic               start_q;

  // memories
  logic [31:0] m_mem [SLOTS];
  logic [55:0] v_mem [SLOTS];
  logic        vld_mem [SLOTS];
  logic [31:0] m_rd_q;
  logic [55:0] v_rd_q;
  logic        vld_rd_q;

  // multiplier
  logic signed [MW-1:0] acc_q, ma_q, mul_a;
  logic [31:0]          mb_q, mul_b;
  logic                 mul_clr;

  // divider
  logic [DNW-1:0] dn_q, div_n;
  logic [DRW-1:0] drem_q, dden_q, div_den;
  logic [DQW-1:0] dq_q, dcap_q, div_cap, div_res;
  logic           dov_q;
  logic [DRW:0]   drem_sh, drem_sub;
  logic [DQW:0]   dq_next;
  logic           dge;

  // square root
  logic [SXW-1:0] sx_q;
  logic [SRW-1:0] srem_q;
  logic [RTW-1:0] sroot_q;
  logic [SRW+1:0] srem_sh, strial;
  logic           sge;

  // intermediate values
  logic signed [31:0] gt_q, m_q;
  logic [54:0]        gsq_q;
  logic [55:0]        v_q;
  logic signed [39:0] mh_q, gh_q;
  logic signed [41:0] num_q, num_d;
  logic [41:0]        num_abs;
  logic               nzero_q;

  logic signed [31:0] m_old;
  logic [55:0]        v_old;
  logic [31:0]        g_abs, m_abs, gt_abs;
  logic [24:0]        wc1, wc2;
  logic [32:0]        d1, d2;
  logic [31:0]        mag;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_idx_q == SLOT_W'(SLOTS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = start_q ? ST_P1 : ST_GT;
      ST_P1:    if (ctl.last) state_d = ST_P2;
      ST_P2:    if (ctl.last) state_d = ST_GT;
      ST_GT:    if (ctl.last) state_d = ST_M;
      ST_M:     if (ctl.last) state_d = ST_GSQ;
      ST_GSQ:   if (ctl.last) state_d = ST_V1;
      ST_V1:    if (ctl.last) state_d = ST_V2;
      ST_V2:    if (ctl.last) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_DMH;
      ST_DMH:   if (ctl.last) state_d = ST_DGH;
      ST_DGH:   if (ctl.last) state_d = ST_DVH;
      ST_DVH:   if (ctl.last) state_d = ST_SQRT;
      ST_SQRT:  if (ctl.last) state_d = ST_NUM;
      ST_NUM:   if (ctl.last) state_d = ST_NMAG;
      ST_NMAG:  if (ctl.last) state_d = ST_DDEL;
      ST_DDEL:  if (ctl.last) state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    ctl.first   = (cnt_q == '0);
    ctl.is_mul  = 1'b0;
    ctl.is_div  = 1'b0;
    ctl.is_sqrt = 1'b0;
    ctl.last    = 1'b0;
    case (state_q)
      ST_P1, ST_P2, ST_GT, ST_M, ST_GSQ, ST_V1, ST_V2, ST_NUM, ST_NMAG: begin
        ctl.is_mul = 1'b1;
        ctl.last   = (cnt_q == MUL_STEPS);
      end
      ST_DMH, ST_DGH, ST_DVH, ST_DDEL: begin
        ctl.is_div = 1'b1;
        ctl.last   = (cnt_q == DIV_STEPS);
      end
      ST_SQRT: begin
        ctl.is_sqrt = 1'b1;
        ctl.last    = (cnt_q == SQRT_STEPS);
      end
      default: ;
    endcase
  end

  // operand selection
  assign m_old  = vld_rd_q ? $signed(m_rd_q) : 32'sd0;
  assign v_old  = vld_rd_q ? v_rd_q : 56'd0;
  assign g_abs  = g_q[31] ? 32'(-g_q) : 32'(g_q);
  assign m_abs  = m_q[31] ? 32'(-m_q) : 32'(m_q);
  assign gt_abs = gt_q[31] ? 32'(-gt_q) : 32'(gt_q);
  assign wc1    = Q24_ONE - {1'b0, b1_q};
  assign wc2    = Q24_ONE - {1'b0, b2_q};
  assign d1     = (p1_q == POW_ONE) ? POW_ONE : POW_ONE - p1_q;
  assign d2     = (p2_q == POW_ONE) ? POW_ONE : POW_ONE - p2_q;
  assign num_d  = {{2{acc_q[63]}}, acc_q[63:24]} + {{2{gh_q[39]}}, gh_q};
  assign num_abs = num_d[41] ? 42'(-num_d) : 42'(num_d);
  assign div_res = dov_q ? dcap_q : dq_q;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_clr = 1'b1;
    case (state_q)
      ST_P1:   begin mul_a = {{(MW-33){1'b0}}, p1_q}; mul_b = {8'd0, b1_q}; end
      ST_P2:   begin mul_a = {{(MW-33){1'b0}}, p2_q}; mul_b = {8'd0, b2_q}; end
      ST_GT:   begin mul_a = {{(MW-32){g_q[31]}}, g_q}; mul_b = {7'd0, wc1}; end
      ST_M: begin
        mul_a   = {{(MW-32){m_old[31]}}, m_old};
        mul_b   = {8'd0, b1_q};
        mul_clr = 1'b0;
      end
      ST_GSQ:  begin mul_a = {{(MW-32){1'b0}}, g_abs}; mul_b = g_abs; end
      ST_V1:   begin mul_a = {{(MW-56){1'b0}}, v_old}; mul_b = {8'd0, b2_q}; end
      ST_V2: begin
        mul_a   = {{(MW-55){1'b0}}, gsq_q};
        mul_b   = {7'd0, wc2};
        mul_clr = 1'b0;
      end
      ST_NUM:  begin mul_a = {{(MW-40){mh_q[39]}}, mh_q}; mul_b = {8'd0, b1_q}; end
      ST_NMAG: begin mul_a = {{(MW-42){1'b0}}, num_abs}; mul_b = {8'd0, eta_q}; end
      default: ;
    endcase
  end

  always_comb begin
    div_n   = '0;
    div_den = {{(DRW-33){1'b0}}, d1};
    div_cap = CAP39;
    case (state_q)
      ST_DMH: div_n = {24'd0, m_abs, 32'd0};
      ST_DGH: div_n = {24'd0, gt_abs, 32'd0};
      ST_DVH: begin
        div_n   = {v_q, 32'd0};
        div_den = {{(DRW-33){1'b0}}, d2};
        div_cap = CAP56;
      end
      ST_DDEL: begin
        div_n   = {8'd0, acc_q[63:0], 16'd0};
        div_den = {1'b0, sroot_q} + {9'd0, eps_q};
        div_cap = (!num_q[41] && (num_q != '0)) ? CAP_NEG : CAP_POS;
      end
      default: ;
    endcase
  end

  // divider and root steps
  assign drem_sh  = {drem_q, dn_q[DNW-1]};
  assign dge      = (drem_sh >= {1'b0, dden_q});
  assign drem_sub = drem_sh - {1'b0, dden_q};
  assign dq_next  = {dq_q, dge};

  assign srem_sh  = {srem_q, sx_q[SXW-1:SXW-2]};
  assign strial   = {2'b00, sroot_q, 2'b01};
  assign sge      = (srem_sh >= strial);

  assign mag = nzero_q ? 32'd0 : div_res[31:0];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
      b1_q        <= BETA_FIRST_RST;
      b2_q        <= BETA_SECOND_RST;
      eta_q       <= ETA_RST;
      eps_q       <= EPS_RST;
      p1_q        <= POW_ONE;
      p2_q        <= POW_ONE;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
      if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + SLOT_W'(1);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_BETA_FIRST:     b1_q  <= cfg_data_i[23:0];
          CFG_BETA_SECOND:    b2_q  <= cfg_data_i[23:0];
          CFG_LEARNING_RATE:  eta_q <= cfg_data_i[23:0];
          CFG_STABILITY_TERM: eps_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_READ && !vld_rd_q && start_q) begin
        p1_q <= POW_ONE;
        p2_q <= POW_ONE;
      end
      if (state_q == ST_P2 && ctl.first) p1_q <= acc_q[56:24];
      if (state_q == ST_GT && ctl.first && start_q) p2_q <= acc_q[56:24];
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q  <= in_item_i.slot_index[SLOT_W-1:0];
      g_q     <= in_item_i.gradient;
      start_q <= in_item_i.call_start;
    end
    if (ctl.is_mul) begin
      if (ctl.first) begin
        ma_q <= mul_a;
        mb_q <= mul_b;
        if (mul_clr) acc_q <= '0;
      end else begin
        if (mb_q[0]) acc_q <= acc_q + ma_q;
        ma_q <= ma_q <<< 1;
        mb_q <= mb_q >> 1;
      end
    end
    if (ctl.is_div) begin
      if (ctl.first) begin
        dn_q   <= div_n;
        dden_q <= div_den;
        dcap_q <= div_cap;
        drem_q <= '0;
        dq_q   <= '0;
        dov_q  <= 1'b0;
      end else begin
        dn_q   <= dn_q << 1;
        drem_q <= dge ? drem_sub[DRW-1:0] : drem_sh[DRW-1:0];
        dq_q   <= dq_next[DQW-1:0];
        if (dq_next > {1'b0, dcap_q}) dov_q <= 1'b1;
      end
    end
    if (ctl.is_sqrt) begin
      if (ctl.first) begin
        sx_q    <= {div_res[55:0], 40'd0};
        srem_q  <= '0;
        sroot_q <= '0;
      end else begin
        sx_q    <= sx_q << 2;
        srem_q  <= sge ? SRW'(srem_sh - strial) : srem_sh[SRW-1:0];
        sroot_q <= {sroot_q[RTW-2:0], sge};
      end
    end
    if (ctl.first) begin
      case (state_q)
        ST_M:    gt_q  <= acc_q[55:24];
        ST_GSQ:  m_q   <= acc_q[55:24];
        ST_V1:   gsq_q <= acc_q[62:8];
        ST_DGH:  mh_q  <= m_q[31] ? -$signed({1'b0, div_res[38:0]})
                                  : $signed({1'b0, div_res[38:0]});
        ST_DVH:  gh_q  <= gt_q[31] ? -$signed({1'b0, div_res[38:0]})
                                   : $signed({1'b0, div_res[38:0]});
        ST_NMAG: num_q <= num_d;
        ST_DDEL: nzero_q <= (acc_q[63:0] == 64'd0);
        default: ;
      endcase
    end
    if (state_q == ST_WRITE) v_q <= acc_q[79:24];
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_q.weight_delta <= (!num_q[41] && (num_q != '0)) ? $signed(-mag) : $signed(mag);
      out_q.saturated    <= !nzero_q && dov_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) m_mem[slot_q] <= m_q;
    if (accept) m_rd_q <= m_mem[in_item_i.slot_index[SLOT_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) v_mem[slot_q] <= acc_q[79:24];
    if (accept) v_rd_q <= v_mem[in_item_i.slot_index[SLOT_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) vld_mem[clr_idx_q] <= 1'b0;
    else if (state_q == ST_WRITE) vld_mem[slot_q] <= 1'b1;
    if (accept) vld_rd_q <= vld_mem[in_item_i.slot_index[SLOT_W-1:0]];
  end

endmodule

// ----- design/nwu_checker.sv -----
`timescale 1ns / 1ps
module nwu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input nwu_pkg::nwu_in_t   in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input nwu_pkg::nwu_out_t  out_item_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input nwu_pkg::cfg_idx_e  cfg_index_i,
  input logic [39:0]        cfg_data_i
);
  import nwu_pkg::*;

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // a clamped delta is never zero
  a_sat_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.saturated) |-> (out_item_o.weight_delta != 32'sd0))
    else $error("saturated flag with zero delta");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_item_o))
    else $error("result changed while stalled");

endmodule

bind nadam_weight_update_unit nwu_checker u_nwu_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import nwu_pkg::*;

  localparam longint unsigned ONE_Q32 = 64'h1_0000_0000;
  localparam longint unsigned ONE_Q24 = 64'h100_0000;
  localparam longint unsigned LIM39   = (64'd1 << 39) - 64'd1;
  localparam longint unsigned LIM56   = (64'd1 << 56) - 64'd1;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  nwu_in_t   in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  nwu_out_t  out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  cfg_idx_e  cfg_index_i = CFG_BETA_FIRST;
  logic [39:0] cfg_data_i = '0;

  nadam_weight_update_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] m_store [SLOTS];
  longint unsigned    v_store [SLOTS];
  bit                 slot_used [SLOTS];
  longint unsigned    pow_b1, pow_b2;
  logic [23:0]        beta1, beta2, eta;
  logic [39:0]        eps;

  nwu_in_t  gradient_queue [$];
  nwu_out_t delta_queue [$];
  int       mismatches = 0;
  int       items_in = 0, deltas_out = 0, sat_seen = 0;
  bit       in_fire = 1'b0;
  bit       idle_on = 1'b1;
  int       tx_gap = 0, rx_gap = 0, hold_left = 0;

  function automatic longint unsigned quot_sat(longint unsigned num, int sh,
      longint unsigned den, longint unsigned cap, output bit over);
    longint unsigned rem, q, b;
    bit ov;
    rem = 0; q = 0; ov = 1'b0;
    for (int p = 63 + sh; p >= 0; p--) begin
      b = (p >= sh) ? ((num >> (p - sh)) & 64'd1) : 64'd0;
      rem = (rem << 1) | b;
      q = q << 1;
      if (rem >= den) begin
        rem -= den;
        q |= 64'd1;
      end
      if (q > cap) begin
        ov = 1'b1;
        q = cap + 64'd1;
      end
    end
    over = ov;
    return ov ? cap : q;
  endfunction

  function automatic longint unsigned root_q40(longint unsigned v);
    longint unsigned rem, r, hi, lo, trial;
    int ph, pl;
    rem = 0; r = 0;
    for (int i = 47; i >= 0; i--) begin
      ph = 2 * i + 1;
      pl = 2 * i;
      hi = (ph >= 40) ? ((v >> (ph - 40)) & 64'd1) : 64'd0;
      lo = (pl >= 40) ? ((v >> (pl - 40)) & 64'd1) : 64'd0;
      rem = (rem << 2) | (hi << 1) | lo;
      trial = (r << 2) | 64'd1;
      r = r << 1;
      if (rem >= trial) begin
        rem -= trial;
        r |= 64'd1;
      end
    end
    return r;
  endfunction

  function automatic longint bias_div(longint x, longint unsigned den);
    longint unsigned mag, q;
    bit ov;
    mag = (x < 0) ? longint'(-x) : x;
    q = quot_sat(mag, 32, den, LIM39, ov);
    return (x < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic nwu_out_t nadam_delta(nwu_in_t it);
    int unsigned s;
    longint g, m, mh, gh, num;
    longint unsigned b1, b2, b1c, b2c, gsq, v, d1, d2, vh, rt, den, nmag, mag, cap;
    bit ov, neg, sat;
    nwu_out_t r;
    s = it.slot_index % SLOTS;
    g = it.gradient;
    b1 = 64'(beta1); b2 = 64'(beta2);
    b1c = ONE_Q24 - b1; b2c = ONE_Q24 - b2;
    sat = 1'b0;
    if (!slot_used[s]) begin
      m_store[s] = '0;
      v_store[s] = 0;
      slot_used[s] = 1'b1;
      if (it.call_start) begin
        pow_b1 = ONE_Q32;
        pow_b2 = ONE_Q32;
      end
    end
    if (it.call_start) begin
      pow_b1 = (pow_b1 * b1) >> 24;
      pow_b2 = (pow_b2 * b2) >> 24;
    end
    m = (longint'(b1) * longint'(m_store[s]) + longint'(b1c) * g) >>> 24;
    m_store[s] = m[31:0];
    m = m_store[s];
    gsq = longint'(g * g) >> 8;
    v = v_store[s];
    v = b2 * (v >> 24) + b2c * (gsq >> 24)
        + ((b2 * (v & (ONE_Q24 - 1)) + b2c * (gsq & (ONE_Q24 - 1))) >> 24);
    v_store[s] = v;
    d1 = ONE_Q32 - pow_b1;
    if (d1 == 0) d1 = ONE_Q32;
    d2 = ONE_Q32 - pow_b2;
    if (d2 == 0) d2 = ONE_Q32;
    mh = bias_div(m, d1);
    gh = bias_div((longint'(b1c) * g) >>> 24, d1);
    vh = quot_sat(v, 32, d2, LIM56, ov);
    rt = root_q40(vh);
    num = ((longint'(b1) * mh) >>> 24) + gh;
    den = rt + longint'(eps);
    nmag = ((num < 0) ? longint'(-num) : num) * longint'(eta);
    neg = num > 0;
    cap = neg ? (64'd1 << 31) : ((64'd1 << 31) - 64'd1);
    if (nmag == 0) mag = 0;
    else if (den == 0) begin
      mag = cap;
      sat = 1'b1;
    end else mag = quot_sat(nmag, 16, den, cap, sat);
    r.weight_delta = neg ? -mag[31:0] : mag[31:0];
    r.saturated = sat;
    return r;
  endfunction

  // capture, prediction and check
  always @(posedge clk_i) begin
    nwu_out_t want;
    if (rst_ni) begin
      in_fire <= in_valid_i && in_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BETA_FIRST:     beta1 = cfg_data_i[23:0];
          CFG_BETA_SECOND:    beta2 = cfg_data_i[23:0];
          CFG_LEARNING_RATE:  eta = cfg_data_i[23:0];
          CFG_STABILITY_TERM: eps = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        delta_queue.push_back(nadam_delta(in_item_i));
        items_in++;
      end
      if (out_valid_o && out_ready_i) begin
        deltas_out++;
        if (out_item_o.saturated) sat_seen++;
        if (delta_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected delta %h", out_item_o);
        end else begin
          want = delta_queue.pop_front();
          if (want.weight_delta !== out_item_o.weight_delta
              || want.saturated !== out_item_o.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("delta mismatch: exp %h sat %b, got %h sat %b",
                       want.weight_delta, want.saturated,
                       out_item_o.weight_delta, out_item_o.saturated);
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(4, 1);
    return $urandom_range(150, 20);
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && !in_fire)) begin
        if (tx_gap > 0) begin
          in_valid_i <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (gradient_queue.size() > 0) begin
          in_valid_i <= 1'b1;
          in_item_i <= gradient_queue.pop_front();
          tx_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (rx_gap > 0) begin
        out_ready_i <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else begin
        out_ready_i <= 1'b1;
        rx_gap <= pick_gap();
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [39:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [23:0] b1, logic [23:0] b2, logic [23:0] lr,
                            logic [39:0] ep);
    write_reg(CFG_BETA_FIRST, 40'(b1));
    write_reg(CFG_BETA_SECOND, 40'(b2));
    write_reg(CFG_LEARNING_RATE, 40'(lr));
    write_reg(CFG_STABILITY_TERM, ep);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (gradient_queue.size() > 0 || in_valid_i || delta_queue.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_item(int slot, logic [31:0] g, bit st);
    nwu_in_t it;
    it.slot_index = slot[9:0];
    it.gradient = g;
    it.call_start = st;
    gradient_queue.push_back(it);
  endtask

  function automatic logic [31:0] rand_gradient();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097152)) - 1048576);
      2: return 32'($signed($urandom_range(134217728)) - 67108864);
      3: case ($urandom_range(4))
           0: return 32'h7fff_ffff;
           1: return 32'h8000_0000;
           2: return 32'h0;
           3: return 32'h1;
           default: return 32'hffff_ffff;
         endcase
      default: return 32'($signed($urandom_range(65536)) - 32768);
    endcase
  endfunction

  function automatic logic [23:0] rand_beta();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hff_ffff;
      2: return BETA_FIRST_RST;
      3: return BETA_SECOND_RST;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_calls(int n);
    int cnt, len, base;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(12, 1);
        base = ($urandom_range(1)) ? $urandom_range(15) : $urandom_range(1023);
        for (int k = 0; k < len; k++) add_item((base + k) % SLOTS, rand_gradient(), k == 0);
        cnt += len;
      end else begin
        add_item($urandom_range(1023), $urandom, 1'($urandom_range(1)));
        cnt++;
      end
    end
  endtask

  initial begin
    logic [23:0] lr;
    logic [39:0] ep;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    pow_b1 = ONE_Q32;
    pow_b2 = ONE_Q32;
    beta1 = BETA_FIRST_RST;
    beta2 = BETA_SECOND_RST;
    eta = ETA_RST;
    eps = EPS_RST;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: no learning rate, powers untouched by a plain item
    add_item(0, 32'h7fff_ffff, 1'b0);
    add_item(1023, 32'h8000_0000, 1'b0);
    add_item(0, 32'h0100_0000, 1'b1);
    drain();
    // zero divisor and zero numerator
    set_config(24'd0, BETA_SECOND_RST, 24'hff_ffff, 40'd0);
    add_item(5, 32'h1, 1'b1);
    add_item(6, 32'h0, 1'b0);
    add_item(7, 32'hffff_ffff, 1'b0);
    drain();
    // upper extremes
    set_config(24'hff_ffff, 24'hff_ffff, 24'hff_ffff, 40'hff_ffff_ffff);
    add_item(8, 32'h7fff_ffff, 1'b1);
    add_item(9, 32'h8000_0000, 1'b0);
    add_item(8, 32'h8000_0000, 1'b1);
    add_item(0, 32'h0000_0001, 1'b1);
    drain();
    set_config(BETA_FIRST_RST, BETA_SECOND_RST, 24'h00_4000, EPS_RST);
    for (int k = 0; k < 10; k++) add_item(k + 100, rand_gradient(), k == 0);
    add_item(100, 32'h7fff_ffff, 1'b1);
    add_item(101, 32'h8000_0000, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph != 3);
      case ($urandom_range(3))
        0: lr = 24'hff_ffff;
        1: lr = 24'($urandom_range(4096, 1));
        2: lr = 24'd0;
        default: lr = 24'($urandom);
      endcase
      case ($urandom_range(3))
        0: ep = 40'd0;
        1: ep = 40'hff_ffff_ffff;
        2: ep = EPS_RST;
        default: ep = 40'({$urandom, $urandom}) & 40'h00_00ff_ffff;
      endcase
      if (ph == 0) set_config(24'hff_ffff, 24'hff_ffff, 24'hff_ffff, 40'hff_ffff_ffff);
      else if (ph == 1) set_config(24'd0, 24'd0, 24'hff_ffff, 40'd0);
      else set_config(rand_beta(), rand_beta(), (lr == 0 && ph > 2) ? 24'h1000 : lr, ep);
      if (ph == 2) hold_left = 5000;
      random_calls(190);
      drain();
    end

    repeat (800) @(posedge clk_i);
    mismatches += delta_queue.size();
    $display("run covered %0d gradient items and %0d deltas, %0d of them saturated",
             items_in, deltas_out, sat_seen);
    $display("configs swept over beta, learning rate and epsilon extremes");
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #60ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
design/nwu_pkg.sv
design/nadam_weight_update_unit.sv
design/nwu_checker.sv
sim/testbench.sv
